// ===== rtl/svg_pkg.sv =====
package svg_pkg;

	localparam int FRAC_BITS_DEF = 14;
	localparam int COUNT_MAX_DEF = 256;

	localparam int PHASE_BITS   = 24;
	localparam int CORDIC_STEPS = 16;
	localparam int DIV_W        = 33;
	localparam int XY_W         = 27;
	localparam int Z_W          = 26;
	localparam int GAIN_INV     = 10188014;
	localparam int PH_QUARTER   = 1 << (PHASE_BITS - 2);
	localparam int PH_HALF      = 1 << (PHASE_BITS - 1);

	localparam logic [1:0] REG_RING_COUNT    = 2'd0;
	localparam logic [1:0] REG_SEGMENT_COUNT = 2'd1;
	localparam logic [1:0] REG_NORMALS       = 2'd2;

	typedef logic signed [XY_W-1:0] xy_t;
	typedef logic signed [Z_W-1:0]  ang_t;

	typedef struct packed {
		logic north;
		logic south;
		logic clamped;
	} meta_t;

	function automatic int atan_step(input int i);
		int r;
		r = 0;
		case (i)
			0:  r = 2097152;
			1:  r = 1238021;
			2:  r = 654136;
			3:  r = 332050;
			4:  r = 166669;
			5:  r = 83416;
			6:  r = 41718;
			7:  r = 20860;
			8:  r = 10430;
			9:  r = 5215;
			10: r = 2608;
			11: r = 1304;
			12: r = 652;
			13: r = 326;
			14: r = 163;
			15: r = 81;
			default: r = 0;
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/svg_div_cell.sv =====
module svg_div_cell #(
	parameter int W = svg_pkg::DIV_W
) (
	input  logic         clk,
	input  logic [W-1:0] num_i,
	input  logic [8:0]   rem_i,
	input  logic [8:0]   den_i,
	input  logic [W-1:0] q_i,
	output logic [W-1:0] num_o,
	output logic [8:0]   rem_o,
	output logic [8:0]   den_o,
	output logic [W-1:0] q_o
);

	logic [9:0] trial;
	logic [9:0] diff;
	logic       ge;

	assign trial = {rem_i, num_i[W-1]};
	assign ge    = trial >= {1'b0, den_i};
	assign diff  = trial - {1'b0, den_i};

	// one quotient bit per cell, remainder stays below the divisor
	always_ff @(posedge clk) begin
		rem_o <= ge ? diff[8:0] : trial[8:0];
		num_o <= {num_i[W-2:0], 1'b0};
		q_o   <= {q_i[W-2:0], ge};
		den_o <= den_i;
	end

endmodule

// ===== rtl/svg_cordic_cell.sv =====
module svg_cordic_cell #(
	parameter int STEP = 0
) (
	input  logic               clk,
	input  svg_pkg::xy_t       x_i,
	input  svg_pkg::xy_t       y_i,
	input  svg_pkg::ang_t      z_i,
	output svg_pkg::xy_t       x_o,
	output svg_pkg::xy_t       y_o,
	output svg_pkg::ang_t      z_o
);

	localparam svg_pkg::ang_t ATAN = svg_pkg::Z_W'(svg_pkg::atan_step(STEP));

	// rotate toward zero residual angle
	always_ff @(posedge clk) begin
		if (!z_i[svg_pkg::Z_W-1]) begin
			x_o <= x_i - (y_i >>> STEP);
			y_o <= y_i + (x_i >>> STEP);
			z_o <= z_i - ATAN;
		end else begin
			x_o <= x_i + (y_i >>> STEP);
			y_o <= y_i - (x_i >>> STEP);
			z_o <= z_i + ATAN;
		end
	end

endmodule

// ===== rtl/sphere_vertex_generator_core.sv =====
// Throughput: one vertex per cycle; start is taken every cycle, busy stays low.
// The depth comes from the 33-cell divider chain, the 16-cell CORDIC chain and
// the multiply and rounding stages. The receiver cannot stall: done is a strobe.
// Reset (arst_n low) clears the pipeline valids and loads the register defaults
// ring_count 16, segment_count 16, normals_enabled 1.
module sphere_vertex_generator_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [7:0]         ring,
	input  logic [8:0]         segment,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [8:0]         cfg_data,
	output logic               done,
	output logic signed [14:0] pos_x,
	output logic signed [14:0] pos_y,
	output logic signed [14:0] pos_z,
	output logic [16:0]        tex_u,
	output logic [16:0]        tex_v,
	output logic signed [15:0] norm_x,
	output logic signed [15:0] norm_y,
	output logic signed [15:0] norm_z,
	output logic               clamped
);

	localparam int FRAC_BITS = svg_pkg::FRAC_BITS_DEF;
	localparam int COUNT_MAX = svg_pkg::COUNT_MAX_DEF;
	localparam int DW    = svg_pkg::DIV_W;
	localparam int NS    = svg_pkg::CORDIC_STEPS;
	localparam int S_DIV = 1 + DW;
	localparam int S_FLD = S_DIV + 1;
	localparam int S_COR = S_FLD + NS;
	localparam int LAT   = S_COR + 3;
	localparam int SH_P  = 49 - FRAC_BITS;
	localparam int SH_Y  = 25 - FRAC_BITS;

	logic [8:0] ring_count_q;
	logic [8:0] segment_count_q;
	logic       normals_enabled_q;

	assign cfg_ready = 1'b1;
	assign busy      = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_count_q      <= 9'd16;
			segment_count_q   <= 9'd16;
			normals_enabled_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				svg_pkg::REG_RING_COUNT:    ring_count_q      <= cfg_data;
				svg_pkg::REG_SEGMENT_COUNT: segment_count_q   <= cfg_data;
				svg_pkg::REG_NORMALS:       normals_enabled_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// ---- input stage: saturate counts, clamp indices, build dividends
	logic        accept;
	logic [8:0]  rc, sc, last;
	logic [7:0]  ring_c;
	logic [8:0]  seg_c;
	logic        clamp_c;

	assign accept = start && !busy;

	always_comb begin
		if (ring_count_q < 9'd3) rc = 9'd3;
		else if (int'(ring_count_q) > COUNT_MAX) rc = 9'(COUNT_MAX);
		else rc = ring_count_q;
		if (segment_count_q < 9'd1) sc = 9'd1;
		else if (int'(segment_count_q) > COUNT_MAX) sc = 9'(COUNT_MAX);
		else sc = segment_count_q;
		last    = rc - 9'd1;
		clamp_c = 1'b0;
		ring_c  = ring;
		seg_c   = segment;
		if ({1'b0, ring} > last) begin
			ring_c  = last[7:0];
			clamp_c = 1'b1;
		end
		if (segment > sc) begin
			seg_c   = sc;
			clamp_c = 1'b1;
		end
	end

	logic [LAT-1:0]   vld_q;
	svg_pkg::meta_t   meta_s [1:LAT-1];
	logic [DW-1:0]    num_c [4][DW+1];
	logic [8:0]       rem_c [4][DW+1];
	logic [8:0]       den_c [4][DW+1];
	logic [DW-1:0]    q_c   [4][DW+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else vld_q <= {vld_q[LAT-2:0], accept};
	end

	always_ff @(posedge clk) begin
		meta_s[1].north   <= ring_c == 8'd0;
		meta_s[1].south   <= {1'b0, ring_c} == last;
		meta_s[1].clamped <= clamp_c;
		for (int k = 2; k <= LAT - 1; k++) meta_s[k] <= meta_s[k-1];
		// lanes: theta phase, phi phase, u quotient, v quotient
		num_c[0][0] <= {2'b0, ring_c, 23'b0} + {25'b0, last[8:1]};
		num_c[1][0] <= {seg_c, 24'b0} + {25'b0, sc[8:1]};
		num_c[2][0] <= {8'b0, seg_c, 16'b0} + {25'b0, sc[8:1]};
		num_c[3][0] <= {9'b0, ring_c, 16'b0} + {25'b0, last[8:1]};
		den_c[0][0] <= last;
		den_c[1][0] <= sc;
		den_c[2][0] <= sc;
		den_c[3][0] <= last;
		rem_c[0][0] <= '0;
		rem_c[1][0] <= '0;
		rem_c[2][0] <= '0;
		rem_c[3][0] <= '0;
		q_c[0][0]   <= '0;
		q_c[1][0]   <= '0;
		q_c[2][0]   <= '0;
		q_c[3][0]   <= '0;
	end

	for (genvar l = 0; l < 4; l++) begin : g_lane
		for (genvar k = 0; k < DW; k++) begin : g_div
			svg_div_cell #(.W(DW)) u_cell (
				.clk   (clk),
				.num_i (num_c[l][k]),
				.rem_i (rem_c[l][k]),
				.den_i (den_c[l][k]),
				.q_i   (q_c[l][k]),
				.num_o (num_c[l][k+1]),
				.rem_o (rem_c[l][k+1]),
				.den_o (den_c[l][k+1]),
				.q_o   (q_c[l][k+1])
			);
		end
	end

	// ---- fold phases into +-quarter turn
	svg_pkg::xy_t  x_c [2][NS+1];
	svg_pkg::xy_t  y_c [2][NS+1];
	svg_pkg::ang_t z_c [2][NS+1];
	logic [1:0]    flip_s [S_FLD:S_COR];
	logic [16:0]   u_s [S_FLD:LAT-1];
	logic [16:0]   v_s [S_FLD:LAT-1];
	svg_pkg::ang_t z_raw [2];
	svg_pkg::ang_t z_fld [2];
	logic [1:0]    flip_c;

	always_comb begin
		for (int a = 0; a < 2; a++) begin
			z_raw[a] = svg_pkg::Z_W'(signed'(q_c[a][DW][svg_pkg::PHASE_BITS-1:0]));
			z_fld[a] = z_raw[a];
			flip_c[a] = 1'b0;
			if (z_raw[a] > svg_pkg::Z_W'(svg_pkg::PH_QUARTER)) begin
				z_fld[a]  = z_raw[a] - svg_pkg::Z_W'(svg_pkg::PH_HALF);
				flip_c[a] = 1'b1;
			end else if (z_raw[a] < -svg_pkg::Z_W'(svg_pkg::PH_QUARTER)) begin
				z_fld[a]  = z_raw[a] + svg_pkg::Z_W'(svg_pkg::PH_HALF);
				flip_c[a] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		x_c[0][0] <= svg_pkg::XY_W'(svg_pkg::GAIN_INV);
		x_c[1][0] <= svg_pkg::XY_W'(svg_pkg::GAIN_INV);
		y_c[0][0] <= '0;
		y_c[1][0] <= '0;
		z_c[0][0] <= z_fld[0];
		z_c[1][0] <= z_fld[1];
		flip_s[S_FLD] <= flip_c;
		for (int k = S_FLD + 1; k <= S_COR; k++) flip_s[k] <= flip_s[k-1];
		u_s[S_FLD] <= 17'd65536 - q_c[2][DW][16:0];
		v_s[S_FLD] <= q_c[3][DW][16:0];
		for (int k = S_FLD + 1; k < LAT; k++) begin
			u_s[k] <= u_s[k-1];
			v_s[k] <= v_s[k-1];
		end
	end

	for (genvar a = 0; a < 2; a++) begin : g_ang
		for (genvar k = 0; k < NS; k++) begin : g_cor
			svg_cordic_cell #(.STEP(k)) u_cell (
				.clk (clk),
				.x_i (x_c[a][k]),
				.y_i (y_c[a][k]),
				.z_i (z_c[a][k]),
				.x_o (x_c[a][k+1]),
				.y_o (y_c[a][k+1]),
				.z_o (z_c[a][k+1])
			);
		end
	end

	// ---- undo the fold, multiply, round
	svg_pkg::xy_t st_s52, ct_s52, sp_s52, cp_s52;
	logic signed [54:0] px_prod_s53, pz_prod_s53;
	svg_pkg::xy_t       ct_s53;

	always_ff @(posedge clk) begin
		st_s52 <= flip_s[S_COR][0] ? -y_c[0][NS] : y_c[0][NS];
		ct_s52 <= flip_s[S_COR][0] ? -x_c[0][NS] : x_c[0][NS];
		sp_s52 <= flip_s[S_COR][1] ? -y_c[1][NS] : y_c[1][NS];
		cp_s52 <= flip_s[S_COR][1] ? -x_c[1][NS] : x_c[1][NS];
		px_prod_s53 <= 55'(st_s52 * cp_s52);
		pz_prod_s53 <= 55'(st_s52 * (-28'(sp_s52)));
		ct_s53      <= ct_s52;
	end

	logic signed [55:0] half_v, rx, rz, ry;
	logic signed [55:0] px_w, py_w, pz_w;

	always_comb begin
		half_v = 56'sd1 <<< (FRAC_BITS - 1);
		rx = (56'(px_prod_s53) + (56'sd1 <<< (SH_P - 1))) >>> SH_P;
		rz = (56'(pz_prod_s53) + (56'sd1 <<< (SH_P - 1))) >>> SH_P;
		ry = (56'(ct_s53) + (56'sd1 <<< (SH_Y - 1))) >>> SH_Y;
		px_w = rx > half_v ? half_v : (rx < -half_v ? -half_v : rx);
		py_w = ry > half_v ? half_v : (ry < -half_v ? -half_v : ry);
		pz_w = rz > half_v ? half_v : (rz < -half_v ? -half_v : rz);
		if (meta_s[LAT-1].north || meta_s[LAT-1].south) begin
			px_w = '0;
			pz_w = '0;
			py_w = meta_s[LAT-1].north ? half_v : -half_v;
		end
	end

	logic done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done_q <= 1'b0;
		else done_q <= vld_q[LAT-2];
	end

	always_ff @(posedge clk) begin
		pos_x   <= px_w[14:0];
		pos_y   <= py_w[14:0];
		pos_z   <= pz_w[14:0];
		norm_x  <= normals_enabled_q ? {px_w[14:0], 1'b0} : 16'sd0;
		norm_y  <= normals_enabled_q ? {py_w[14:0], 1'b0} : 16'sd0;
		norm_z  <= normals_enabled_q ? {pz_w[14:0], 1'b0} : 16'sd0;
		clamped <= meta_s[LAT-1].clamped;
		if (meta_s[LAT-1].north || meta_s[LAT-1].south) begin
			tex_u <= 17'd32768;
			tex_v <= meta_s[LAT-1].north ? 17'd0 : 17'd65536;
		end else begin
			tex_u <= u_s[LAT-1];
			tex_v <= v_s[LAT-1];
		end
	end

	assign done = done_q;

	a_u_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> tex_u <= 17'd65536)
		else $error("tex_u out of range");

	a_north: assert property (@(posedge clk) disable iff (!arst_n)
		done && tex_v == 17'd0 |-> pos_x == 15'sd0 && pos_z == 15'sd0)
		else $error("north pole word not on axis");

	a_nrm_off: assert property (@(posedge clk) disable iff (!arst_n)
		done && !normals_enabled_q |-> norm_x == 16'sd0 && norm_y == 16'sd0 && norm_z == 16'sd0)
		else $error("normals present while disabled");

endmodule

// ===== dv/tb_sphere_vertex_generator_core.sv =====
`timescale 1ns / 1ps

module tb_sphere_vertex_generator_core;

	localparam logic [1:0] REG_UNUSED = 2'd3;
	localparam int LATENCY = 54;

	typedef struct packed {
		logic signed [14:0] px;
		logic signed [14:0] py;
		logic signed [14:0] pz;
		logic [16:0]        u;
		logic [16:0]        v;
		logic signed [15:0] nx;
		logic signed [15:0] ny;
		logic signed [15:0] nz;
		logic               clamp;
	} vertex_t;

	typedef struct packed {
		logic [7:0] ring;
		logic [8:0] seg;
		logic       typed;
		vertex_t    want;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [7:0] ring = '0;
	logic [8:0] segment = '0;
	logic cfg_valid = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [8:0] cfg_data = '0;
	logic busy, cfg_ready, done;
	vertex_t got;

	logic [8:0] ring_cnt_q = 9'd16;
	logic [8:0] seg_cnt_q = 9'd16;
	logic normals_q = 1'b1;

	vertex_t pending_vertices[$];
	int mismatches = 0;
	int idle_pct = 0;

	sphere_vertex_generator_core u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.ring(ring), .segment(segment),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.done(done), .pos_x(got.px), .pos_y(got.py), .pos_z(got.pz),
		.tex_u(got.u), .tex_v(got.v),
		.norm_x(got.nx), .norm_y(got.ny), .norm_z(got.nz),
		.clamped(got.clamp)
	);

	always #5 clk = ~clk;

	initial begin
		#2ms;
		$display("simulation failed");
		$finish;
	end

	function automatic longint atan_table(input int i);
		longint steps[16] = '{2097152, 1238021, 654136, 332050, 166669, 83416, 41718,
			20860, 10430, 5215, 2608, 1304, 652, 326, 163, 81};
		return steps[i];
	endfunction

	// rotation CORDIC on a 2^24 phase circle, 24 fraction bits out
	task automatic cordic(input longint phase, output longint s, output longint c);
		longint z, x, y, t;
		bit flip;
		z = phase & ((64'd1 << svg_pkg::PHASE_BITS) - 1);
		x = svg_pkg::GAIN_INV;
		y = 0;
		flip = 1'b0;
		if (z >= svg_pkg::PH_HALF) z -= 2 * svg_pkg::PH_HALF;
		if (z > svg_pkg::PH_QUARTER) begin
			z -= svg_pkg::PH_HALF;
			flip = 1'b1;
		end else if (z < -svg_pkg::PH_QUARTER) begin
			z += svg_pkg::PH_HALF;
			flip = 1'b1;
		end
		for (int i = 0; i < svg_pkg::CORDIC_STEPS; i++) begin
			if (z >= 0) begin
				t = x - (y >>> i);
				y = y + (x >>> i);
				z -= atan_table(i);
			end else begin
				t = x + (y >>> i);
				y = y - (x >>> i);
				z += atan_table(i);
			end
			x = t;
		end
		s = flip ? -y : y;
		c = flip ? -x : x;
	endtask

	function automatic longint round_sat(input longint v, input int sh);
		longint r;
		r = (v + (64'sd1 <<< (sh - 1))) >>> sh;
		if (r > 8192) r = 8192;
		if (r < -8192) r = -8192;
		return r;
	endfunction

	task automatic vertex_of(input logic [7:0] r_in, input logic [8:0] s_in,
			output vertex_t vx);
		longint rc, sc, last, r, s, px, py, pz, st, ct, sp, cp, u, v;
		rc = ring_cnt_q;
		sc = seg_cnt_q;
		vx = '0;
		if (rc < 3) rc = 3;
		if (rc > 256) rc = 256;
		if (sc < 1) sc = 1;
		if (sc > 256) sc = 256;
		last = rc - 1;
		r = r_in;
		s = s_in;
		if (r > last) begin
			r = last;
			vx.clamp = 1'b1;
		end
		if (s > sc) begin
			s = sc;
			vx.clamp = 1'b1;
		end
		if (r == 0 || r == last) begin
			px = 0;
			pz = 0;
			py = (r == 0) ? 8192 : -8192;
			u = 32768;
			v = (r == 0) ? 0 : 65536;
		end else begin
			cordic(((r << 23) + last / 2) / last, st, ct);
			cordic(((s << 24) + sc / 2) / sc, sp, cp);
			px = round_sat(st * cp, 35);
			py = round_sat(ct, 11);
			pz = round_sat(-(st * sp), 35);
			u = 65536 - ((s << 16) + sc / 2) / sc;
			v = ((r << 16) + last / 2) / last;
		end
		vx.px = 15'(px);
		vx.py = 15'(py);
		vx.pz = 15'(pz);
		vx.u = 17'(u);
		vx.v = 17'(v);
		if (normals_q) begin
			vx.nx = 16'(2 * px);
			vx.ny = 16'(2 * py);
			vx.nz = 16'(2 * pz);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_vertices.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected vertex %p", got);
			end else begin
				if (pending_vertices[0] !== got) begin
					mismatches++;
					if (mismatches <= 10)
						$display("vertex mismatch: expected %p actual %p",
							pending_vertices[0], got);
				end
				void'(pending_vertices.pop_front());
			end
		end
	end

	// hold start until the word is taken
	task automatic send_vertex(input logic [7:0] r, input logic [8:0] s, input bit typed,
			input vertex_t want);
		vertex_t vx;
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		if (typed) vx = want;
		else vertex_of(r, s, vx);
		ring <= r;
		segment <= s;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		pending_vertices = {pending_vertices, vx};
	endtask

	task automatic drain;
		start <= 1'b0;
		@(posedge clk);
		while (pending_vertices.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [8:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			svg_pkg::REG_RING_COUNT:    ring_cnt_q = val;
			svg_pkg::REG_SEGMENT_COUNT: seg_cnt_q = val;
			svg_pkg::REG_NORMALS:       normals_q = val[0];
			default: ;
		endcase
	endtask

	task automatic random_vertices(input int n);
		int rc, sc;
		logic [7:0] r;
		logic [8:0] s;
		rc = (ring_cnt_q < 3) ? 3 : (ring_cnt_q > 256 ? 256 : ring_cnt_q);
		sc = (seg_cnt_q < 1) ? 1 : (seg_cnt_q > 256 ? 256 : seg_cnt_q);
		for (int k = 0; k < n; k++) begin
			if ($urandom_range(9) == 0) begin
				r = 8'($urandom);
				s = 9'($urandom);
			end else begin
				r = 8'($urandom_range(rc - 1));
				s = 9'($urandom_range(sc));
			end
			send_vertex(r, s, 1'b0, '0);
		end
	endtask

	initial begin
		row_t rows[$];
		int cfg_sets[8][3];
		vertex_t north, south;
		north = '{px: 0, py: 8192, pz: 0, u: 32768, v: 0, nx: 0, ny: 16384, nz: 0,
			clamp: 0};
		south = '{px: 0, py: -8192, pz: 0, u: 32768, v: 65536, nx: 0, ny: -16384, nz: 0,
			clamp: 0};
		rows = {rows, row_t'{8'd0, 9'd0, 1'b1, north}};
		rows = {rows, row_t'{8'd0, 9'd16, 1'b1, north}};
		rows = {rows, row_t'{8'd15, 9'd0, 1'b1, south}};
		south.clamp = 1'b1;
		rows = {rows, row_t'{8'd255, 9'd511, 1'b1, south}};
		rows = {rows, row_t'{8'd16, 9'd3, 1'b1, south}};
		north.clamp = 1'b1;
		rows = {rows, row_t'{8'd0, 9'd17, 1'b1, north}};
		rows = {rows, row_t'{8'd1, 9'd0, 1'b0, '0}};
		rows = {rows, row_t'{8'd1, 9'd16, 1'b0, '0}};
		rows = {rows, row_t'{8'd7, 9'd4, 1'b0, '0}};
		rows = {rows, row_t'{8'd8, 9'd8, 1'b0, '0}};
		rows = {rows, row_t'{8'd14, 9'd12, 1'b0, '0}};
		rows = {rows, row_t'{8'd3, 9'd1, 1'b0, '0}};
		rows = {rows, row_t'{8'd5, 9'd17, 1'b0, '0}};
		rows = {rows, row_t'{8'd9, 9'd256, 1'b0, '0}};
		rows = {rows, row_t'{8'd170, 9'd85, 1'b0, '0}};
		rows = {rows, row_t'{8'd85, 9'd170, 1'b0, '0}};

		cfg_sets = '{'{3, 1, 0}, '{256, 256, 1}, '{0, 0, 1}, '{511, 511, 0},
			'{5, 7, 1}, '{2, 300, 0}, '{200, 3, 1}, '{16, 16, 1}};

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) send_vertex(rows[i].ring, rows[i].seg, rows[i].typed, rows[i].want);
		drain();
		write_reg(REG_UNUSED, 9'h1FF);
		random_vertices(20);
		drain();

		for (int p = 0; p < 12; p++) begin
			if (p < 8) begin
				write_reg(svg_pkg::REG_RING_COUNT, 9'(cfg_sets[p][0]));
				write_reg(svg_pkg::REG_SEGMENT_COUNT, 9'(cfg_sets[p][1]));
				write_reg(svg_pkg::REG_NORMALS, 9'(cfg_sets[p][2]));
			end else begin
				write_reg(svg_pkg::REG_RING_COUNT, 9'($urandom));
				write_reg(svg_pkg::REG_SEGMENT_COUNT, 9'($urandom));
				write_reg(svg_pkg::REG_NORMALS, 9'($urandom));
			end
			case (p % 3)
				0: idle_pct = 0;
				1: idle_pct = 79;
				default: idle_pct = 9;
			endcase
			random_vertices(165);
			drain();
		end

		repeat (LATENCY + 10) @(posedge clk);
		if (mismatches == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
